@@ hdl/kct_pkg.sv @@
// Package for the keycode to character translator.
// Holds key codes, field widths, event value codes and the character key slot map.
// Used by keycode_to_char_translator.sv and its testbench; depends on nothing.
package kct_pkg;

    // Field widths of the stream items.
    localparam int CODE_W = 10;
    localparam int CHAR_W = 21;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 6;
    localparam int SLOT_W = 6;

    // Key event values.
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;
    localparam logic [1:0] VAL_REPEAT  = 2'd2;
    localparam logic [1:0] VAL_OTHER   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_REPEAT     = 2'd0;
    localparam logic [1:0] KIND_REPEAT_END = 2'd1;
    localparam logic [1:0] KIND_RANGE      = 2'd2;
    localparam logic [1:0] KIND_PRESS      = 2'd3;

    // Table columns.
    localparam logic [1:0] COL_PLAIN = 2'd0;
    localparam logic [1:0] COL_SHIFT = 2'd1;
    localparam logic [1:0] COL_ALTGR = 2'd2;
    localparam logic [1:0] COL_NONE  = 2'd3;

    // Modifier and lock key codes.
    localparam logic [CODE_W-1:0] CODE_CAPSLOCK = 10'd58;
    localparam logic [CODE_W-1:0] CODE_LSHIFT   = 10'd42;
    localparam logic [CODE_W-1:0] CODE_RSHIFT   = 10'd54;
    localparam logic [CODE_W-1:0] CODE_RALT     = 10'd100;
    localparam logic [CODE_W-1:0] CODE_LCTRL    = 10'd29;
    localparam logic [CODE_W-1:0] CODE_RCTRL    = 10'd97;
    localparam logic [CODE_W-1:0] CODE_EXTRA    = 10'd86;
    localparam logic [SLOT_W-1:0] SLOT_EXTRA    = 6'd47;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } key_slot_t;

    // Maps a key code to its character key slot; hit is low for other keys.
    function automatic key_slot_t key_slot(input logic [CODE_W-1:0] code);
        key_slot_t           r;
        logic [CODE_W-1:0]   d;
        r = '0;
        d = '0;
        if (code >= 10'd2 && code <= 10'd13) begin
            d = code - 10'd2;
            r.hit = 1'b1;
        end else if (code >= 10'd16 && code <= 10'd27) begin
            d = code - 10'd4;
            r.hit = 1'b1;
        end else if (code >= 10'd30 && code <= 10'd41) begin
            d = code - 10'd6;
            r.hit = 1'b1;
        end else if (code >= 10'd43 && code <= 10'd53) begin
            d = code - 10'd7;
            r.hit = 1'b1;
        end else if (code == CODE_EXTRA) begin
            d = CODE_W'(SLOT_EXTRA);
            r.hit = 1'b1;
        end
        r.slot = d[SLOT_W-1:0];
        return r;
    endfunction

endpackage

@@ hdl/kct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the character table columns; depends on nothing.
module kct_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; the read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/keycode_to_char_translator.sv @@
// Keycode to character translator, top level.
// Depends on kct_pkg.sv and kct_ram.sv.
//
// The block takes one item per clock cycle on its input stream, both key
// events and character table writes, while s_tready is high. A table write
// goes into the table at the edge where it is accepted; a key event starts
// its read of the plain, shift and altgr columns at that same edge and moves
// into stage 1. From stage 1 the event is translated, the hold, lock and
// repeat state is updated and any result is loaded into the output register;
// an event that yields a result waits in stage 1 while the output register
// holds a result that is not taken. The sustained rate is one item per cycle
// while the output stream does not stall, set by the single read per event on
// the table memories. While a result waits in the output register, one more
// event can move into stage 1; if that event also yields a result, it holds
// the input until the waiting result is transferred. The table reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
module keycode_to_char_translator #(
    parameter int CHAR_KEY_COUNT = 48,
    parameter int CODE_LIMIT     = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: bit 0 capslock_at_start.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: key_code[9:0], key_value[11:10], table_index[17:12],
    // table_column[19:18], table_char[40:20], table_alpha[41], zeros above.
    input  logic [47:0] s_tdata,
    // tuser: mode[0], is_key_event[1].
    input  logic [1:0]  s_tuser,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: key_code_out[9:0], char_out[30:10], repeat_count[46:31],
    // shift_state[47], caps_on[48], altgr_on[49], ctrl_on[50], zeros above.
    output logic [55:0] m_tdata,
    // tuser: event_kind[1:0].
    output logic [1:0]  m_tuser
);

    localparam int AW     = $clog2(CHAR_KEY_COUNT);
    localparam int CODE_W = kct_pkg::CODE_W;
    localparam int CHAR_W = kct_pkg::CHAR_W;
    localparam int CNT_W  = kct_pkg::CNT_W;

    // Input field unpacking.
    logic                          in_mode;
    logic                          in_is_key;
    logic [CODE_W-1:0]             in_code;
    logic [1:0]                    in_value;
    logic [kct_pkg::IDX_W-1:0]     in_index;
    logic [1:0]                    in_column;
    logic [CHAR_W-1:0]             in_char;
    logic                          in_alpha;

    assign in_mode   = s_tuser[0];
    assign in_is_key = s_tuser[1];
    assign in_code   = s_tdata[9:0];
    assign in_value  = s_tdata[11:10];
    assign in_index  = s_tdata[17:12];
    assign in_column = s_tdata[19:18];
    assign in_char   = s_tdata[40:20];
    assign in_alpha  = s_tdata[41];

    // Configuration is always taken.
    logic cfg_fire;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Handshake signals.
    logic in_fire;
    logic s1_go;
    logic s1_emit;
    logic out_load;
    logic out_free;

    // Stage 1 registers: the key event waiting for its table read data.
    logic                 s1_valid_reg;
    logic [CODE_W-1:0]    s1_code_reg;
    logic [1:0]           s1_value_reg;
    logic                 s1_hit_reg;
    logic                 s1_pv_reg;
    logic                 s1_sv_reg;
    logic                 s1_av_reg;

    // Translator state.
    logic [CNT_W-1:0]     rep_cnt_reg,  rep_cnt_next;
    logic [CHAR_W-1:0]    last_char_reg, last_char_next;
    logic                 shift_reg,    shift_next;
    logic                 caps_reg,     caps_next;
    logic                 altgr_reg,    altgr_next;
    logic                 ctrl_reg,     ctrl_next;
    logic [1:0]           kind_next;

    // Valid bits for each table entry, one row per column.
    logic [CHAR_KEY_COUNT-1:0] plain_vld_reg;
    logic [CHAR_KEY_COUNT-1:0] shift_vld_reg;
    logic [CHAR_KEY_COUNT-1:0] altgr_vld_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [1:0]           m_kind_reg;
    logic [CODE_W-1:0]    m_code_reg;
    logic [CHAR_W-1:0]    m_char_reg;
    logic [CNT_W-1:0]     m_cnt_reg;
    logic                 m_shift_reg;
    logic                 m_caps_reg;
    logic                 m_altgr_reg;
    logic                 m_ctrl_reg;

    assign out_free = ~m_tvalid_reg | m_tready;
    assign s1_go    = s1_valid_reg & (~s1_emit | out_free);
    assign s_tready = ~s1_valid_reg | s1_go;
    assign in_fire  = s_tvalid & s_tready;
    assign out_load = s1_go & s1_emit;

    // Table write decode at acceptance.
    logic            wr_ok;
    logic [AW-1:0]   wr_addr;
    logic            we_plain, we_shift, we_altgr;

    assign wr_ok    = in_fire & in_mode & (in_column != kct_pkg::COL_NONE)
                      & ({1'b0, in_index} < (kct_pkg::IDX_W + 1)'(CHAR_KEY_COUNT));
    assign wr_addr  = in_index[AW-1:0];
    assign we_plain = wr_ok & (in_column == kct_pkg::COL_PLAIN);
    assign we_shift = wr_ok & (in_column == kct_pkg::COL_SHIFT);
    assign we_altgr = wr_ok & (in_column == kct_pkg::COL_ALTGR);

    // Table read at acceptance of a key event.
    kct_pkg::key_slot_t in_slot;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    assign in_slot = kct_pkg::key_slot(in_code);
    assign rd_en   = in_fire & ~in_mode & in_is_key;
    assign rd_addr = in_slot.slot[AW-1:0];

    logic [CHAR_W:0]   rd_plain;
    logic [CHAR_W-1:0] rd_shift;
    logic [CHAR_W-1:0] rd_altgr;

    // Plain column carries the alpha flag in its top bit.
    kct_ram #(.WIDTH(CHAR_W + 1), .DEPTH(CHAR_KEY_COUNT)) u_plain_ram (
        .aclk  (aclk),
        .we    (we_plain),
        .waddr (wr_addr),
        .wdata ({in_alpha, in_char}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_plain)
    );

    kct_ram #(.WIDTH(CHAR_W), .DEPTH(CHAR_KEY_COUNT)) u_shift_ram (
        .aclk  (aclk),
        .we    (we_shift),
        .waddr (wr_addr),
        .wdata (in_char),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_shift)
    );

    kct_ram #(.WIDTH(CHAR_W), .DEPTH(CHAR_KEY_COUNT)) u_altgr_ram (
        .aclk  (aclk),
        .we    (we_altgr),
        .waddr (wr_addr),
        .wdata (in_char),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_altgr)
    );

    // Valid bits: cleared by reset, set by the first write of each entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_vld_reg <= '0;
            shift_vld_reg <= '0;
            altgr_vld_reg <= '0;
        end else begin
            if (we_plain) begin
                plain_vld_reg[wr_addr] <= 1'b1;
            end
            if (we_shift) begin
                shift_vld_reg[wr_addr] <= 1'b1;
            end
            if (we_altgr) begin
                altgr_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Stage 1 control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= rd_en;
        end
    end

    // Stage 1 payload, sampled with the table read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s1_code_reg  <= in_code;
            s1_value_reg <= in_value;
            s1_hit_reg   <= in_slot.hit;
            s1_pv_reg    <= plain_vld_reg[rd_addr];
            s1_sv_reg    <= shift_vld_reg[rd_addr];
            s1_av_reg    <= altgr_vld_reg[rd_addr];
        end
    end

    // Table entries as seen by the event; unwritten entries read as zero.
    logic [CHAR_W-1:0] ent_plain;
    logic [CHAR_W-1:0] ent_shift;
    logic [CHAR_W-1:0] ent_altgr;
    logic              ent_alpha;
    logic [CHAR_W-1:0] pick;

    assign ent_plain = s1_pv_reg ? rd_plain[CHAR_W-1:0] : '0;
    assign ent_alpha = s1_pv_reg & rd_plain[CHAR_W];
    assign ent_shift = s1_sv_reg ? rd_shift : '0;
    assign ent_altgr = s1_av_reg ? rd_altgr : '0;

    // Character selection with the altgr, caps lock and shift fallbacks.
    always_comb begin
        if (altgr_reg) begin
            if (ent_altgr != '0) begin
                pick = ent_altgr;
            end else begin
                pick = shift_reg ? ent_shift : ent_plain;
            end
        end else if (caps_reg && ent_alpha) begin
            pick = shift_reg ? ent_plain : ent_shift;
            if (pick == '0) begin
                pick = ent_plain;
            end
        end else if (shift_reg) begin
            pick = (ent_shift != '0) ? ent_shift : ent_plain;
        end else begin
            pick = ent_plain;
        end
    end

    // Event decode and next state.
    logic is_shift_key;
    logic is_ctrl_key;
    logic in_range;

    assign is_shift_key = (s1_code_reg == kct_pkg::CODE_LSHIFT)
                          || (s1_code_reg == kct_pkg::CODE_RSHIFT);
    assign is_ctrl_key  = (s1_code_reg == kct_pkg::CODE_LCTRL)
                          || (s1_code_reg == kct_pkg::CODE_RCTRL);
    assign in_range     = s1_code_reg < CODE_W'(CODE_LIMIT);

    always_comb begin
        rep_cnt_next   = rep_cnt_reg;
        last_char_next = last_char_reg;
        shift_next     = shift_reg;
        caps_next      = caps_reg;
        altgr_next     = altgr_reg;
        ctrl_next      = ctrl_reg;
        kind_next      = kct_pkg::KIND_PRESS;
        s1_emit        = 1'b0;
        case (s1_value_reg)
            kct_pkg::VAL_REPEAT: begin
                if (rep_cnt_reg != kct_pkg::CNT_MAX) begin
                    rep_cnt_next = rep_cnt_reg + 1'b1;
                end
                kind_next = kct_pkg::KIND_REPEAT;
                s1_emit   = 1'b1;
            end
            kct_pkg::VAL_RELEASE: begin
                if (is_shift_key) begin
                    shift_next = 1'b0;
                end else if (s1_code_reg == kct_pkg::CODE_RALT) begin
                    altgr_next = 1'b0;
                end else if (is_ctrl_key) begin
                    ctrl_next = 1'b0;
                end
                kind_next = kct_pkg::KIND_REPEAT_END;
                s1_emit   = rep_cnt_reg != '0;
            end
            default: begin
                // Press or any other value.
                rep_cnt_next = '0;
                if (!in_range) begin
                    kind_next = kct_pkg::KIND_RANGE;
                    s1_emit   = 1'b1;
                end else begin
                    last_char_next = '0;
                    if (s1_value_reg == kct_pkg::VAL_PRESS) begin
                        s1_emit = 1'b1;
                        if (s1_code_reg == kct_pkg::CODE_CAPSLOCK) begin
                            caps_next = ~caps_reg;
                        end else if (is_shift_key) begin
                            shift_next = 1'b1;
                        end else if (s1_code_reg == kct_pkg::CODE_RALT) begin
                            altgr_next = 1'b1;
                        end else if (is_ctrl_key) begin
                            ctrl_next = 1'b1;
                        end else if (s1_hit_reg) begin
                            last_char_next = pick;
                        end
                    end
                end
            end
        endcase
    end

    // State update; a configuration write loads caps lock directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_cnt_reg   <= '0;
            last_char_reg <= '0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            altgr_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
        end else begin
            if (s1_go) begin
                rep_cnt_reg   <= rep_cnt_next;
                last_char_reg <= last_char_next;
                shift_reg     <= shift_next;
                caps_reg      <= caps_next;
                altgr_reg     <= altgr_next;
                ctrl_reg      <= ctrl_next;
            end
            if (cfg_fire) begin
                caps_reg <= cfg_data;
            end
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg  <= kind_next;
            m_code_reg  <= s1_code_reg;
            m_char_reg  <= last_char_next;
            m_cnt_reg   <= rep_cnt_next;
            m_shift_reg <= shift_next;
            m_caps_reg  <= caps_next;
            m_altgr_reg <= altgr_next;
            m_ctrl_reg  <= ctrl_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'b0, m_ctrl_reg, m_altgr_reg, m_caps_reg, m_shift_reg,
                       m_cnt_reg, m_char_reg, m_code_reg};

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_load && m_tvalid_reg && !m_tready))
        else $error("output register overwritten while stalled");

    // The input side is open whenever stage 1 is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with an empty stage 1");

    // An autorepeat always leaves a nonzero repeat count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_value_reg == kct_pkg::VAL_REPEAT) |=> (rep_cnt_reg != '0))
        else $error("repeat count zero after autorepeat");

    // Reset empties stage 1 and the output register.
    assert property (@(posedge aclk)
        !aresetn |=> (!s1_valid_reg && !m_tvalid_reg))
        else $error("pipeline not empty after reset");

endmodule

@@ test/keycode_to_char_translator_tb.sv @@
// Self-checking testbench for the keycode to character translator.
// It streams key events and table writes, predicts each translation and compares the results.
// Depends on kct_pkg.sv and keycode_to_char_translator.sv.
`timescale 1ns / 100ps

module keycode_to_char_translator_tb;

    localparam int          KEY_SLOTS  = 48;
    localparam int          CODE_LIMIT = 128;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam int          SETTLE     = 8;
    localparam int          HOLD_OFF   = 200;
    localparam int          NO_XFER_MAX = 2000;

    // One input item, every field of both tdata and tuser.
    typedef struct packed {
        logic        mode;
        logic        is_key;
        logic        alpha;
        logic [20:0] cp;
        logic [1:0]  column;
        logic [5:0]  index;
        logic [1:0]  value;
        logic [9:0]  code;
    } key_item_t;

    // One translation result.
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  code;
        logic [20:0] chr;
        logic [15:0] count;
        logic        shift;
        logic        caps;
        logic        altgr;
        logic        ctrl;
    } key_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    key_item_t   keys_to_send[$];
    key_result_t translations_due[$];

    // Predicted state of the block.
    logic [20:0] plain_col[KEY_SLOTS];
    logic [20:0] shift_col[KEY_SLOTS];
    logic [20:0] altgr_col[KEY_SLOTS];
    logic        alpha_key[KEY_SLOTS];
    logic [15:0] repeats;
    logic [20:0] cur_char;
    logic        shift_hold;
    logic        caps_lock;
    logic        altgr_hold;
    logic        ctrl_hold;

    int          gap_pct = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_left = 0;
    bit          hold_request = 1'b0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    key_item_t   next_key;
    key_result_t want;
    key_result_t got;

    keycode_to_char_translator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Appends an item to the send queue.
    function automatic void enqueue(key_item_t it);
        keys_to_send.insert(keys_to_send.size(), it);
    endfunction

    // Slot of a character key in the table, or -1 for any other code.
    function automatic int char_slot(logic [9:0] c);
        if (c inside {[10'd2:10'd13]}) return int'(c) - 2;
        if (c inside {[10'd16:10'd27]}) return int'(c) - 4;
        if (c inside {[10'd30:10'd41]}) return int'(c) - 6;
        if (c inside {[10'd43:10'd53]}) return int'(c) - 7;
        if (c == kct_pkg::CODE_EXTRA) return int'(kct_pkg::SLOT_EXTRA);
        return -1;
    endfunction

    // Code point a character key press yields under the current holds and lock.
    function automatic logic [20:0] select_char(int s);
        logic [20:0] pick;
        if (altgr_hold) begin
            pick = altgr_col[s];
            if (pick == '0) pick = shift_hold ? shift_col[s] : plain_col[s];
        end else if (caps_lock && alpha_key[s]) begin
            pick = shift_hold ? plain_col[s] : shift_col[s];
            if (pick == '0) pick = plain_col[s];
        end else if (shift_hold) begin
            pick = shift_col[s];
            if (pick == '0) pick = plain_col[s];
        end else begin
            pick = plain_col[s];
        end
        return pick;
    endfunction

    // Applies one accepted item to the predicted state and queues its result, if any.
    task automatic translate_item(input logic [47:0] d, input logic [1:0] u);
        logic [9:0]  code;
        logic [1:0]  val;
        logic [5:0]  idx;
        logic [1:0]  col;
        int          s;
        bit          emits;
        key_result_t r;
        code  = d[9:0];
        val   = d[11:10];
        idx   = d[17:12];
        col   = d[19:18];
        emits = 1'b0;
        r     = '0;
        if (u[0]) begin
            if (idx < KEY_SLOTS && col != kct_pkg::COL_NONE) begin
                case (col)
                    kct_pkg::COL_PLAIN: begin
                        plain_col[idx] = d[40:20];
                        alpha_key[idx] = d[41];
                    end
                    kct_pkg::COL_SHIFT: shift_col[idx] = d[40:20];
                    default:            altgr_col[idx] = d[40:20];
                endcase
            end
        end else if (u[1]) begin
            case (val)
                kct_pkg::VAL_REPEAT: begin
                    if (repeats != kct_pkg::CNT_MAX) repeats = repeats + 16'd1;
                    emits  = 1'b1;
                    r.kind = kct_pkg::KIND_REPEAT;
                end
                kct_pkg::VAL_RELEASE: begin
                    if (code == kct_pkg::CODE_LSHIFT || code == kct_pkg::CODE_RSHIFT)
                        shift_hold = 1'b0;
                    else if (code == kct_pkg::CODE_RALT)
                        altgr_hold = 1'b0;
                    else if (code == kct_pkg::CODE_LCTRL || code == kct_pkg::CODE_RCTRL)
                        ctrl_hold = 1'b0;
                    if (repeats != '0) begin
                        emits  = 1'b1;
                        r.kind = kct_pkg::KIND_REPEAT_END;
                    end
                end
                default: begin
                    repeats = '0;
                    if (code >= CODE_LIMIT) begin
                        emits  = 1'b1;
                        r.kind = kct_pkg::KIND_RANGE;
                    end else begin
                        cur_char = '0;
                        if (val == kct_pkg::VAL_PRESS) begin
                            emits  = 1'b1;
                            r.kind = kct_pkg::KIND_PRESS;
                            if (code == kct_pkg::CODE_CAPSLOCK)
                                caps_lock = ~caps_lock;
                            else if (code == kct_pkg::CODE_LSHIFT ||
                                     code == kct_pkg::CODE_RSHIFT)
                                shift_hold = 1'b1;
                            else if (code == kct_pkg::CODE_RALT)
                                altgr_hold = 1'b1;
                            else if (code == kct_pkg::CODE_LCTRL ||
                                     code == kct_pkg::CODE_RCTRL)
                                ctrl_hold = 1'b1;
                            else begin
                                s = char_slot(code);
                                if (s >= 0) cur_char = select_char(s);
                            end
                        end
                    end
                end
            endcase
            if (emits) begin
                r.code  = code;
                r.chr   = cur_char;
                r.count = repeats;
                r.shift = shift_hold;
                r.caps  = caps_lock;
                r.altgr = altgr_hold;
                r.ctrl  = ctrl_hold;
                translations_due.insert(translations_due.size(), r);
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Item builders.
    function automatic key_item_t key_event(logic [9:0] code, logic [1:0] val);
        key_item_t it;
        it        = '0;
        it.is_key = 1'b1;
        it.code   = code;
        it.value  = val;
        return it;
    endfunction

    function automatic key_item_t table_write(int idx, logic [1:0] col, logic [20:0] cp,
                                              logic alpha);
        key_item_t it;
        it        = '0;
        it.mode   = 1'b1;
        it.index  = 6'(idx);
        it.column = col;
        it.cp     = cp;
        it.alpha  = alpha;
        return it;
    endfunction

    function automatic logic [9:0] slot_code(int s);
        if (s < 12) return 10'(s + 2);
        if (s < 24) return 10'(s + 4);
        if (s < 36) return 10'(s + 6);
        if (s < 47) return 10'(s + 7);
        return kct_pkg::CODE_EXTRA;
    endfunction

    function automatic logic [9:0] modifier_code();
        case ($urandom_range(0, 5))
            0:       return kct_pkg::CODE_LSHIFT;
            1:       return kct_pkg::CODE_RSHIFT;
            2:       return kct_pkg::CODE_RALT;
            3:       return kct_pkg::CODE_LCTRL;
            4:       return kct_pkg::CODE_RCTRL;
            default: return kct_pkg::CODE_CAPSLOCK;
        endcase
    endfunction

    // Random item with every field filled; the mix favors events that reach the table.
    function automatic key_item_t random_item();
        key_item_t it;
        int        r;
        it.mode   = 1'b0;
        it.is_key = 1'b1;
        it.code   = 10'($urandom_range(0, 767));
        it.value  = 2'($urandom);
        it.index  = 6'($urandom);
        it.column = 2'($urandom);
        it.cp     = 21'($urandom_range(0, int'(CP_MAX)));
        it.alpha  = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.mode   = 1'b1;
            it.is_key = 1'($urandom);
            if ($urandom_range(0, 5) == 0) it.cp = '0;
            if ($urandom_range(0, 7) != 0) it.index = 6'($urandom_range(0, KEY_SLOTS - 1));
        end else if (r < 20) begin
            it.is_key = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) it.code = slot_code($urandom_range(0, KEY_SLOTS - 1));
            else if (r < 70) it.code = modifier_code();
            else if (r < 80) it.code = 10'($urandom_range(CODE_LIMIT, 767));
            else it.code = 10'($urandom_range(0, CODE_LIMIT - 1));
            r = $urandom_range(0, 99);
            if (r < 50) it.value = kct_pkg::VAL_PRESS;
            else if (r < 75) it.value = kct_pkg::VAL_RELEASE;
            else if (r < 90) it.value = kct_pkg::VAL_REPEAT;
            else it.value = kct_pkg::VAL_OTHER;
        end
        return it;
    endfunction

    // A typed key: optional modifier held around a press, some repeats and a release.
    task automatic queue_keystroke();
        logic [9:0] mod;
        logic [9:0] key;
        int         n;
        bit         with_mod;
        mod      = modifier_code();
        key      = slot_code($urandom_range(0, KEY_SLOTS - 1));
        with_mod = ($urandom_range(0, 2) != 0);
        if (with_mod) enqueue(key_event(mod, kct_pkg::VAL_PRESS));
        enqueue(key_event(key, kct_pkg::VAL_PRESS));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        repeat (n) enqueue(key_event(key, kct_pkg::VAL_REPEAT));
        enqueue(key_event(key, kct_pkg::VAL_RELEASE));
        if (with_mod) enqueue(key_event(mod, kct_pkg::VAL_RELEASE));
    endtask

    // Fills all three columns of every slot, or of random slots for a partial load; some get zero.
    task automatic queue_table_load(int slots);
        int s;
        for (int k = 0; k < slots; k++) begin
            s = (slots == KEY_SLOTS) ? k : $urandom_range(0, KEY_SLOTS - 1);
            enqueue(table_write(s, kct_pkg::COL_PLAIN,
                ($urandom_range(0, 9) == 0) ? 21'd0 : 21'($urandom_range(1, int'(CP_MAX))),
                1'($urandom)));
            enqueue(table_write(s, kct_pkg::COL_SHIFT,
                ($urandom_range(0, 2) == 0) ? 21'd0 : 21'($urandom_range(1, int'(CP_MAX))),
                1'($urandom)));
            enqueue(table_write(s, kct_pkg::COL_ALTGR,
                ($urandom_range(0, 4) < 3) ? 21'd0 : 21'($urandom_range(1, int'(CP_MAX))),
                1'($urandom)));
        end
    endtask

    task automatic queue_random(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_keystroke();
                sent += 4;
            end else begin
                enqueue(random_item());
                sent++;
            end
        end
    endtask

    // Short walk through the table fallbacks, the holds and the special events.
    task automatic queue_directed();
        enqueue(table_write(24, kct_pkg::COL_PLAIN, 21'h61, 1'b1));
        enqueue(table_write(24, kct_pkg::COL_SHIFT, 21'h41, 1'b0));
        enqueue(table_write(47, kct_pkg::COL_ALTGR, CP_MAX, 1'b0));
        enqueue(table_write(0, kct_pkg::COL_PLAIN, 21'h31, 1'b0));
        enqueue(table_write(63, kct_pkg::COL_PLAIN, CP_MAX, 1'b1));
        enqueue(table_write(5, kct_pkg::COL_NONE, 21'h1234, 1'b1));
        enqueue('{mode: 1'b0, is_key: 1'b0, code: 10'd30, value: kct_pkg::VAL_PRESS,
                  default: '0});
        enqueue(key_event(10'd30, kct_pkg::VAL_PRESS));
        enqueue(key_event(10'd30, kct_pkg::VAL_REPEAT));
        enqueue(key_event(10'd30, kct_pkg::VAL_RELEASE));
        enqueue(key_event(10'd30, kct_pkg::VAL_RELEASE));
        enqueue(key_event(kct_pkg::CODE_LSHIFT, kct_pkg::VAL_PRESS));
        enqueue(key_event(10'd30, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_CAPSLOCK, kct_pkg::VAL_PRESS));
        enqueue(key_event(10'd30, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_LSHIFT, kct_pkg::VAL_RELEASE));
        enqueue(key_event(10'd30, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_RSHIFT, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_RALT, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_EXTRA, kct_pkg::VAL_PRESS));
        enqueue(key_event(10'd2, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_LCTRL, kct_pkg::VAL_PRESS));
        enqueue(key_event(kct_pkg::CODE_RCTRL, kct_pkg::VAL_RELEASE));
        enqueue(key_event(10'd767, kct_pkg::VAL_PRESS));
        enqueue(key_event(10'd30, kct_pkg::VAL_OTHER));
        enqueue(key_event(10'd0, kct_pkg::VAL_REPEAT));
        enqueue(key_event(10'd128, kct_pkg::VAL_OTHER));
    endtask

    // Register write on the configuration channel; only called while the block is idle.
    task automatic write_capslock(input logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every item is sent and every translation has come back.
    task automatic drain();
        while (keys_to_send.size() != 0 || s_tvalid || translations_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Sender: presents the next queued item, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (keys_to_send.size() != 0 && gap_pct != 0 &&
                         $urandom_range(0, 99) < gap_pct) begin
                tx_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else if (keys_to_send.size() != 0) begin
                next_key = keys_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, next_key.alpha, next_key.cp, next_key.column,
                             next_key.index, next_key.value, next_key.code};
                s_tuser  <= {next_key.is_key, next_key.mode};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF - 1;
            m_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            rx_gap = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Prediction from the transfers seen on the input and configuration channels.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                plain_col[k] = '0;
                shift_col[k] = '0;
                altgr_col[k] = '0;
                alpha_key[k] = 1'b0;
            end
            repeats    = '0;
            cur_char   = '0;
            shift_hold = 1'b0;
            caps_lock  = 1'b0;
            altgr_hold = 1'b0;
            ctrl_hold  = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                caps_lock = cfg_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                translate_item(s_tdata, s_tuser);
                items_sent++;
            end
        end
    end

    // Result check against the oldest predicted translation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.code  = m_tdata[9:0];
            got.chr   = m_tdata[30:10];
            got.count = m_tdata[46:31];
            got.shift = m_tdata[47];
            got.caps  = m_tdata[48];
            got.altgr = m_tdata[49];
            got.ctrl  = m_tdata[50];
            results_seen++;
            if (translations_due.size() == 0) begin
                $error("unexpected result: kind %0d, key code %0d", got.kind, got.code);
                mismatches++;
            end else begin
                want = translations_due.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(got.kind));
                check_field("key_code_out", 32'(want.code), 32'(got.code));
                check_field("char_out", 32'(want.chr), 32'(got.chr));
                check_field("repeat_count", 32'(want.count), 32'(got.count));
                check_field("shift_state", 32'(want.shift), 32'(got.shift));
                check_field("caps_on", 32'(want.caps), 32'(got.caps));
                check_field("altgr_on", 32'(want.altgr), 32'(got.altgr));
                check_field("ctrl_on", 32'(want.ctrl), 32'(got.ctrl));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= NO_XFER_MAX) begin
            $error("no transfer for %0d cycles, %0d results still due",
                   idle_cycles, translations_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        int rand_pct[4];
        rand_pct = '{0, 20, 50, 35};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass with the lock register at its reset value.
        gap_pct = 25;
        queue_directed();
        drain();

        // Random passes, alternating the lock register between its two values.
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = rand_pct[ph];
            write_capslock((ph % 2) == 0);
            queue_table_load((ph == 0) ? KEY_SLOTS : 12);
            queue_random(230);
            drain();
        end

        // Long receiver hold-off while presses keep coming, to back up the input.
        gap_pct = 0;
        write_capslock(1'b1);
        hold_request = 1'b1;
        repeat (80) enqueue(
            key_event(slot_code($urandom_range(0, KEY_SLOTS - 1)), kct_pkg::VAL_PRESS));
        drain();

        // Final pass without idling: a press, a run of repeats, two releases and random items.
        write_capslock(1'b0);
        enqueue(key_event(10'd30, kct_pkg::VAL_PRESS));
        repeat (20) enqueue(key_event(10'd30, kct_pkg::VAL_REPEAT));
        enqueue(key_event(10'd30, kct_pkg::VAL_RELEASE));
        enqueue(key_event(10'd30, kct_pkg::VAL_RELEASE));
        queue_random(40);
        drain();

        $display("Run covered %0d input transfers, %0d checked results and %0d lock writes,",
                 items_sent, results_seen, cfg_writes);
        $display("including table fallbacks, modifier holds, a long output stall and repeat runs.");
        if (mismatches == 0 && translations_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ keycode_to_char_translator.f @@
hdl/kct_pkg.sv
hdl/kct_ram.sv
hdl/keycode_to_char_translator.sv
test/keycode_to_char_translator_tb.sv
